@@ src/ipr_pkg.sv @@
// Package for the isolated pixel remover: field widths, register indexes,
// command codes and the request descriptor passed from control to judge.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipr_pkg;

  // pixel and channel widths
  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;

  // configuration register widths and port shape
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // frame limits and reset values
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int ROW_W         = 12;
  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;

  // command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // red levels
  localparam logic [CH_W-1:0] RED_BLACK = 8'h00;
  localparam logic [CH_W-1:0] RED_WHITE = 8'hFF;

  // one output request in flight between control and judge
  typedef struct packed {
    logic valid;       // request carries a result
    logic chk_up;      // not first row
    logic chk_down;    // not last row
    logic chk_left;    // not first column
    logic chk_right;   // not last column
    logic force_keep;  // a needed newer neighbour was never received
    logic ctr_live;    // entry written since reset
    logic up_live;
    logic down_live;
    logic right_live;
    logic frame_end;   // last row and last column
  } emit_info_t;

endpackage

`default_nettype wire

@@ src/isolated_pixel_remover_core.sv @@
// Isolated pixel remover, 4-neighbour. Takes one request per clock (pixel or
// flush) while the output is not blocked and gives each pixel back one
// row plus one pixel later; a black pixel whose in-frame neighbours are all
// white leaves as white with removed set. Results pass the registered ring
// reads and judge stage, then the output register; the rate is set by one
// ring write and four ring reads per cycle over two stores (full pixel store
// and red-only copy), each with two read ports. Width or height register
// writes restart the stream. No clearing pass after reset: a fill count marks
// the ring entries written since reset, the rest read as zero.
// Depends on ipr_pkg, ipr_ctrl, ipr_ring_mem, ipr_judge.
`timescale 1ns / 1ps
`default_nettype none

module isolated_pixel_remover_core import ipr_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [PIX_W-1:0]       s_tdata,  // red_in, green_in, blue_in
  input  wire logic                   s_tuser,  // cmd
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [PIX_W-1:0]            m_tdata,  // red_out, green_out, blue_out
  output logic                        m_tuser,  // removed
  output logic                        m_tlast   // frame_end
);

  localparam int RING = 2 * MAX_WIDTH + 2;
  localparam int AW   = $clog2(RING);

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic             mem_re;
  logic [AW-1:0]    ctr_addr, right_addr, up_addr, down_addr;
  emit_info_t       info;
  logic [PIX_W-1:0] ctr_pix, right_pix;
  logic [CH_W-1:0]  up_red, down_red;

  // pointers, position and address generation
  ipr_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .ready      (s_tready),
    .s_tuser    (s_tuser),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_re     (mem_re),
    .ctr_addr   (ctr_addr),
    .right_addr (right_addr),
    .up_addr    (up_addr),
    .down_addr  (down_addr),
    .info       (info)
  );

  // full pixel store: center and right neighbour
  ipr_ring_mem #(.DATA_W(PIX_W), .DEPTH(RING)) u_pix_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (s_tdata),
    .re     (mem_re),
    .addr_a (ctr_addr),
    .addr_b (right_addr),
    .rd_a   (ctr_pix),
    .rd_b   (right_pix)
  );

  // red copy: neighbours one row up and one row down
  ipr_ring_mem #(.DATA_W(CH_W), .DEPTH(RING)) u_red_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (s_tdata[CH_W-1:0]),
    .re     (mem_re),
    .addr_a (up_addr),
    .addr_b (down_addr),
    .rd_a   (up_red),
    .rd_b   (down_red)
  );

  // removal decision and output register
  ipr_judge u_judge (
    .clk       (clk),
    .rst       (rst),
    .info      (info),
    .ctr_pix   (ctr_pix),
    .right_pix (right_pix),
    .up_red    (up_red),
    .down_red  (down_red),
    .ready     (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

`ifndef SYNTHESIS
  // input stalls only behind a held result
  ap_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a blocked result");

  // a removed pixel always leaves white
  ap_removed_white: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == {PIX_W{1'b1}}))
    else $error("removed pixel is not white");

  // no result right after reset
  ap_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

@@ src/ipr_ring_mem.sv @@
// Ring store: one write port, two registered read ports.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module ipr_ring_mem #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 2050
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr_a,
  input  wire logic [$clog2(DEPTH)-1:0] addr_b,
  output logic      [DATA_W-1:0]        rd_a,
  output logic      [DATA_W-1:0]        rd_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

endmodule

`default_nettype wire

@@ src/ipr_ctrl.sv @@
// Control for the isolated pixel remover: configuration registers, ring
// pointers, pending count, output position and neighbour address generation.
// Depends on ipr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipr_ctrl import ipr_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]               cfg_index,
  input  wire logic [CFG_DATA_W-1:0]                cfg_data,
  input  wire logic                                 s_tvalid,
  input  wire logic                                 ready,
  input  wire logic                                 s_tuser,
  output logic                                      mem_we,
  output logic [$clog2(2*MAX_WIDTH+2)-1:0]          mem_waddr,
  output logic                                      mem_re,
  output logic [$clog2(2*MAX_WIDTH+2)-1:0]          ctr_addr,
  output logic [$clog2(2*MAX_WIDTH+2)-1:0]          right_addr,
  output logic [$clog2(2*MAX_WIDTH+2)-1:0]          up_addr,
  output logic [$clog2(2*MAX_WIDTH+2)-1:0]          down_addr,
  output emit_info_t                                info
);

  localparam int RING    = 2 * MAX_WIDTH + 2;
  localparam int AW      = $clog2(RING);
  localparam int FW      = $clog2(RING + 1);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int PW      = $clog2(MAX_WIDTH + 2);
  localparam int COLW    = $clog2(MAX_WIDTH);
  localparam int CMPW    = (WW > CFG_WIDTH_W) ? WW : CFG_WIDTH_W;
  localparam int W_RESET = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

  logic [WW-1:0]           eff_w;
  logic [CFG_HEIGHT_W-1:0] eff_h;
  logic [AW-1:0]           wr_ptr;
  logic [AW-1:0]           rd_ptr;
  logic [PW-1:0]           pending;
  logic [FW-1:0]           fill;
  logic [COLW-1:0]         out_col;
  logic [ROW_W-1:0]        out_row;

  logic              accept;
  logic              is_pixel;
  logic              emit;
  logic [PW-1:0]     old;
  logic [PW-1:0]     w_ext;
  logic              first_row, last_row, first_col, last_col;
  logic [AW:0]       dn_sum;
  logic [AW:0]       up_sum;
  logic [CMPW-1:0]   w_cfg;
  logic [WW-1:0]     w_sat;
  logic [CFG_HEIGHT_W-1:0] h_cfg;
  logic [CFG_HEIGHT_W-1:0] h_sat;

  // saturate register writes into their meaningful ranges
  always_comb begin
    w_cfg = CMPW'(cfg_data[CFG_WIDTH_W-1:0]);
    if (w_cfg < CMPW'(2)) begin
      w_sat = WW'(2);
    end else if (w_cfg > CMPW'(MAX_WIDTH)) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = w_cfg[WW-1:0];
    end
    h_cfg = cfg_data[CFG_HEIGHT_W-1:0];
    if (h_cfg < CFG_HEIGHT_W'(2)) begin
      h_sat = CFG_HEIGHT_W'(2);
    end else if (h_cfg > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
      h_sat = CFG_HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_sat = h_cfg;
    end
  end

  // request decode and position flags
  always_comb begin
    accept    = s_tvalid && ready;
    is_pixel  = (s_tuser == CMD_PIXEL);
    w_ext     = PW'(eff_w);
    emit      = is_pixel ? (pending > w_ext) : (pending != '0);
    old       = is_pixel ? pending : (pending - PW'(1));
    first_row = (out_row == '0);
    last_row  = ({1'b0, out_row} >= (eff_h - CFG_HEIGHT_W'(1)));
    first_col = (out_col == '0);
    last_col  = (WW'(out_col) >= (eff_w - WW'(1)));
  end

  // neighbour slots around the oldest pending pixel
  always_comb begin
    dn_sum = {1'b0, rd_ptr} + (AW+1)'(eff_w);
    up_sum = {1'b0, rd_ptr} + (AW+1)'(RING) - (AW+1)'(eff_w);
    ctr_addr  = rd_ptr;
    right_addr = (rd_ptr == AW'(RING - 1)) ? '0 : (rd_ptr + AW'(1));
    down_addr = (dn_sum >= (AW+1)'(RING)) ? AW'(dn_sum - (AW+1)'(RING)) : dn_sum[AW-1:0];
    up_addr   = (up_sum >= (AW+1)'(RING)) ? AW'(up_sum - (AW+1)'(RING)) : up_sum[AW-1:0];
  end

  // memory requests and descriptor for the judge stage
  always_comb begin
    mem_we          = accept && is_pixel;
    mem_waddr       = wr_ptr;
    mem_re          = accept && emit;
    info.valid      = accept && emit;
    info.chk_up     = !first_row;
    info.chk_down   = !last_row;
    info.chk_left   = !first_col;
    info.chk_right  = !last_col;
    info.force_keep = (!last_row && (old < w_ext)) || (!last_col && (old == '0));
    info.ctr_live   = (FW'(ctr_addr) < fill);
    info.up_live    = (FW'(up_addr) < fill);
    info.down_live  = (FW'(down_addr) < fill);
    info.right_live = (FW'(right_addr) < fill);
    info.frame_end  = last_row && last_col;
  end

  // configuration, pointers and output position
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w   <= WW'(W_RESET);
      eff_h   <= CFG_HEIGHT_W'(RESET_HEIGHT);
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      pending <= '0;
      fill    <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  eff_w <= w_sat;
        REG_IMAGE_HEIGHT: eff_h <= h_sat;
        default: ;
      endcase
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      pending <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (accept) begin
      // pixel write into the ring
      if (is_pixel) begin
        wr_ptr <= (wr_ptr == AW'(RING - 1)) ? '0 : (wr_ptr + AW'(1));
        if (FW'(wr_ptr) >= fill) begin
          fill <= FW'(wr_ptr) + FW'(1);
        end
      end
      // pending count
      if (is_pixel && !emit) begin
        pending <= pending + PW'(1);
      end else if (!is_pixel && emit) begin
        pending <= pending - PW'(1);
      end
      // advance the output position
      if (emit) begin
        rd_ptr <= right_addr;
        if (last_col) begin
          out_col <= '0;
          out_row <= last_row ? '0 : (out_row + ROW_W'(1));
        end else begin
          out_col <= out_col + COLW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ src/ipr_judge.sv @@
// Judge stage and output register: decides removal from the neighbour reds
// read from the ring stores and holds the result for the output channel.
// Depends on ipr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipr_judge import ipr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire emit_info_t       info,
  input  wire logic [PIX_W-1:0] ctr_pix,
  input  wire logic [PIX_W-1:0] right_pix,
  input  wire logic [CH_W-1:0]  up_red,
  input  wire logic [CH_W-1:0]  down_red,
  output logic                  ready,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [PIX_W-1:0]      m_tdata,  // red_out, green_out, blue_out
  output logic                  m_tuser,  // removed
  output logic                  m_tlast   // frame_end
);

  emit_info_t       st;
  logic [CH_W-1:0]  left_red;
  logic             adv;
  logic [PIX_W-1:0] ctr_val;
  logic [CH_W-1:0]  ctr_red;
  logic             up_ok, down_ok, left_ok, right_ok;
  logic             rm;

  // removal decision
  always_comb begin
    ctr_val  = st.ctr_live ? ctr_pix : '0;
    ctr_red  = ctr_val[CH_W-1:0];
    up_ok    = !st.chk_up || (st.up_live && (up_red == RED_WHITE));
    down_ok  = !st.chk_down || (st.down_live && (down_red == RED_WHITE));
    left_ok  = !st.chk_left || (left_red == RED_WHITE);
    right_ok = !st.chk_right || (st.right_live && (right_pix[CH_W-1:0] == RED_WHITE));
    rm       = (ctr_red == RED_BLACK) && !st.force_keep && up_ok && down_ok &&
               left_ok && right_ok;
    adv      = st.valid && (!m_tvalid || m_tready);
    ready    = !st.valid || adv;
  end

  // stage and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      st.valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (info.valid) begin
        st <= info;
      end else if (adv) begin
        st.valid <= 1'b0;
      end
      if (adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output payload and left neighbour of the next pixel
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata  <= rm ? {PIX_W{1'b1}} : ctr_val;
      m_tuser  <= rm;
      m_tlast  <= st.frame_end;
      left_red <= ctr_red;
    end
  end

endmodule

`default_nettype wire
